// ===== rtl/fault_record_table_assert.svh =====
// Assertion macros used by the fault record table top module
`ifndef FAULT_RECORD_TABLE_ASSERT_SVH
`define FAULT_RECORD_TABLE_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle
`define FRT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check that a condition implies a consequence in the next cycle
`define FRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/frt_pkg.sv =====
package frt_pkg;

    localparam int DEFAULT_DEPTH = 16;
    localparam logic [31:0] WINDOW_RESET = 32'd300000;

    typedef enum logic [1:0] {
        FUNC_REPORT = 2'd0,
        FUNC_SET_REC = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_QUERY = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_INSERTED = 2'd1,
        ST_DROPPED = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    localparam logic [2:0] SEV_WARNING = 3'd1;
    localparam logic [2:0] SEV_ERROR = 3'd2;
    localparam logic [2:0] SEV_CRITICAL = 3'd3;
    localparam logic [2:0] SEV_FATAL = 3'd4;

    // Record held by one cell
    typedef struct packed {
        logic valid;
        logic [2:0] category;
        logic [31:0] code;
        logic [2:0] severity;
        logic [31:0] last_time;
        logic [15:0] count;
        logic recovered;
    } rec_t;

    // Command broadcast to every cell when the scan is over
    typedef struct packed {
        logic wr;
        logic insert;
        logic upd_report;
        logic upd_flag;
        logic flag_value;
        logic clear;
        logic [2:0] category;
        logic [31:0] code;
        logic [2:0] severity;
        logic [31:0] now;
    } cmd_t;

    // Score penalty for one record
    function automatic logic [6:0] penalty(input logic [2:0] sev);
        logic [6:0] p;
        begin
            p = 7'd0;
            if (sev == SEV_WARNING) p = 7'd5;
            else if (sev == SEV_ERROR) p = 7'd10;
            else if (sev == SEV_CRITICAL) p = 7'd20;
            else if (sev == SEV_FATAL) p = 7'd100;
            return p;
        end
    endfunction

    function automatic logic [6:0] sat_sub(input logic [6:0] s, input logic [6:0] d);
        return (s > d) ? s - d : 7'd0;
    endfunction

endpackage

// ===== rtl/fault_record_table.sv =====
// Fault record table.
// Input channel s_axis_*: one word is one request (report, set recovered flag,
// clear category, health query). Output channel m_axis_*: one result word per
// request. cfg_we/cfg_wdata write the recent window (ms); the user must write
// it only while idle, which the block does not enforce. The records sit in a
// ring of TABLE_DEPTH cells that rotates one place per cycle during the scan.
// A request is taken, then the ring turns TABLE_DEPTH times while the head
// cell is inspected (key match, free slot, oldest recovered entry, entry
// counts, score sum); after a full turn every cell is back in place and the
// apply state writes the update to the selected cell (a clear goes to every
// cell of its category). The result is loaded into m_axis on that same edge
// if the output register is free. A new request is taken only in idle, once
// the previous one has been applied. A result held by a stalled receiver is
// kept in the output register; a new request is still accepted and scanned,
// and its result waits until the old one is taken. Reset empties the table
// (valid bits cleared), sets the window to 300000, drops any pending result.
module fault_record_table #(
    parameter int TABLE_DEPTH = frt_pkg::DEFAULT_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // func[1:0], category[4:2], severity[7:5], error_code[39:8], now_ms[71:40],
    // recovered_value[72], errors_active[73], in_recovery[74], zero pad
    input  logic [79:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[1:0], occurrence_count[17:2], health_score[24:18], evicted[25],
    // entries_used[30:26], zero pad
    output logic [31:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata
);
    import frt_pkg::*;
    `include "fault_record_table_assert.svh"

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_APPLY = 4'b0100,
        S_WAIT = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [31:0] window_reg;
    logic [74:0] req_reg;
    logic [IW-1:0] cnt_reg;
    logic hit_reg, free_reg, rec_found_reg;
    logic [IW-1:0] hit_idx_reg, free_idx_reg, old_idx_reg;
    logic [31:0] old_time_reg;
    logic [15:0] hit_count_reg;
    logic [6:0] score_reg;
    logic [CW-1:0] used_reg;
    logic [CW-1:0] cat_cnt_reg;
    logic [31:0] out_reg;
    logic out_valid_reg;
    logic [31:0] res_reg;

    rec_t recs [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] sel;
    cmd_t cmd;
    logic shift;
    logic [IW-1:0] tgt_idx;

    logic [1:0] r_func;
    logic [2:0] r_cat, r_sev;
    logic [31:0] r_code, r_now;
    logic r_rv, r_ea, r_ir;
    assign r_func = req_reg[1:0];
    assign r_cat = req_reg[4:2];
    assign r_sev = req_reg[7:5];
    assign r_code = req_reg[39:8];
    assign r_now = req_reg[71:40];
    assign r_rv = req_reg[72];
    assign r_ea = req_reg[73];
    assign r_ir = req_reg[74];

    assign shift = (state_reg == S_SCAN);

    // Ring of cells: head is cell 0, data moves from cell i+1 to cell i
    for (genvar g = 0; g < TABLE_DEPTH; g++)
    begin : g_cell
        frt_cell u_cell (
            .clk(clk), .rst_n(rst_n), .shift(shift),
            .prev_rec(recs[(g + 1) % TABLE_DEPTH]),
            .sel(sel[g]), .cmd(cmd), .rec(recs[g])
        );
        assign sel[g] = (tgt_idx == IW'(g));
    end

    // Decide the action at the end of the scan
    logic do_insert, do_evict, drop;
    always_comb
    begin
        do_insert = 1'b0;
        do_evict = 1'b0;
        drop = 1'b0;
        tgt_idx = hit_idx_reg;
        if (r_func == FUNC_REPORT && !hit_reg)
        begin
            if (free_reg)
            begin
                do_insert = 1'b1;
                tgt_idx = free_idx_reg;
            end
            else if (rec_found_reg)
            begin
                do_insert = 1'b1;
                do_evict = 1'b1;
                tgt_idx = old_idx_reg;
            end
            else
                drop = 1'b1;
        end
        cmd.wr = (state_reg == S_APPLY);
        cmd.insert = do_insert;
        cmd.upd_report = (r_func == FUNC_REPORT) && hit_reg;
        cmd.upd_flag = (r_func == FUNC_SET_REC) && hit_reg;
        cmd.flag_value = r_rv;
        cmd.clear = (r_func == FUNC_CLEAR);
        cmd.category = r_cat;
        cmd.code = r_code;
        cmd.severity = r_sev;
        cmd.now = r_now;
    end

    // Build the result word
    logic [1:0] res_status;
    logic [15:0] res_count;
    logic [6:0] res_score;
    logic [CW-1:0] res_used;
    always_comb
    begin
        res_status = ST_DONE;
        res_count = 16'd0;
        res_score = 7'd0;
        res_used = used_reg;
        unique case (r_func)
            FUNC_REPORT:
            begin
                if (hit_reg)
                    res_count = (hit_count_reg == 16'hFFFF) ? hit_count_reg
                                                             : hit_count_reg + 16'd1;
                else if (drop)
                    res_status = ST_DROPPED;
                else
                begin
                    res_status = ST_INSERTED;
                    res_count = 16'd1;
                    if (!do_evict)
                        res_used = used_reg + CW'(1);
                end
            end
            FUNC_SET_REC:
            begin
                if (hit_reg)
                    res_count = hit_count_reg;
                else
                    res_status = ST_NOT_FOUND;
            end
            FUNC_CLEAR:
                res_used = used_reg - cat_cnt_reg;
            FUNC_QUERY:
                res_score = sat_sub(sat_sub(score_reg, r_ea ? 7'd10 : 7'd0),
                                    r_ir ? 7'd15 : 7'd0);
            default: ;
        endcase
    end

    // Head cell inspection
    rec_t head;
    logic head_match, head_live;
    logic [31:0] age;
    assign head = recs[0];
    assign head_match = head.valid && head.category == r_cat && head.code == r_code;
    assign age = r_now - head.last_time;
    assign head_live = head.valid && !head.recovered && (age < window_reg);

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (s_axis_tvalid) state_next = S_SCAN;
            S_SCAN: if (cnt_reg == IW'(TABLE_DEPTH - 1)) state_next = S_APPLY;
            S_APPLY:
                if (!out_valid_reg || m_axis_tready) state_next = S_IDLE;
                else state_next = S_WAIT;
            S_WAIT: if (m_axis_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Control registers, window and scan counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            window_reg <= WINDOW_RESET;
            out_valid_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                window_reg <= cfg_wdata;
            if (state_reg == S_SCAN)
                cnt_reg <= cnt_reg + IW'(1);
            else
                cnt_reg <= '0;
            // load a new word, or drop the one just taken
            if (state_reg == S_APPLY && (!out_valid_reg || m_axis_tready))
                out_valid_reg <= 1'b1;
            else if (state_reg == S_WAIT && m_axis_tready)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload and scan registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && s_axis_tvalid)
        begin
            req_reg <= s_axis_tdata[74:0];
            hit_reg <= 1'b0;
            free_reg <= 1'b0;
            rec_found_reg <= 1'b0;
            score_reg <= 7'd100;
            used_reg <= '0;
            cat_cnt_reg <= '0;
        end
        if (state_reg == S_SCAN)
        begin
            if (head_match && !hit_reg)
            begin
                hit_reg <= 1'b1;
                hit_idx_reg <= cnt_reg;
                hit_count_reg <= head.count;
            end
            if (!head.valid && !free_reg)
            begin
                free_reg <= 1'b1;
                free_idx_reg <= cnt_reg;
            end
            if (head.valid && head.recovered &&
                (!rec_found_reg || head.last_time < old_time_reg))
            begin
                rec_found_reg <= 1'b1;
                old_idx_reg <= cnt_reg;
                old_time_reg <= head.last_time;
            end
            if (head.valid)
                used_reg <= used_reg + CW'(1);
            if (head.valid && head.category == r_cat)
                cat_cnt_reg <= cat_cnt_reg + CW'(1);
            if (head_live)
                score_reg <= sat_sub(score_reg, penalty(head.severity));
        end
        if (state_reg == S_APPLY)
            res_reg <= {1'b0, 5'(res_used), do_evict, res_score, res_count, res_status};
        if (state_reg == S_APPLY && (!out_valid_reg || m_axis_tready))
            out_reg <= {1'b0, 5'(res_used), do_evict, res_score, res_count, res_status};
        else if (state_reg == S_WAIT && m_axis_tready)
            out_reg <= res_reg;
    end

    `FRT_ASSERT_IMPL(a_ready_idle, clk, rst_n, s_axis_tready, !shift)
    `FRT_ASSERT_NEXT(a_scan_start, clk, rst_n, s_axis_tvalid && s_axis_tready,
                     state_reg == S_SCAN)
    `FRT_ASSERT_IMPL(a_score_range, clk, rst_n, m_axis_tvalid,
                     m_axis_tdata[24:18] <= 7'd100)
endmodule

// ===== rtl/frt_cell.sv =====
module frt_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          shift,
    input  frt_pkg::rec_t prev_rec,
    input  logic          sel,
    input  frt_pkg::cmd_t cmd,
    output frt_pkg::rec_t rec
);
    import frt_pkg::*;

    rec_t rec_reg;
    rec_t rec_next;
    logic valid_reg;
    logic valid_next;

    // Rotate in scan; update the chosen cell or clear a category
    always_comb
    begin
        rec_next = rec_reg;
        valid_next = valid_reg;
        if (shift)
        begin
            rec_next = prev_rec;
            valid_next = prev_rec.valid;
        end
        else if (cmd.wr)
        begin
            if (cmd.clear)
            begin
                if (valid_reg && rec_reg.category == cmd.category)
                    valid_next = 1'b0;
            end
            else if (sel)
            begin
                if (cmd.insert)
                begin
                    valid_next = 1'b1;
                    rec_next.category = cmd.category;
                    rec_next.code = cmd.code;
                    rec_next.severity = cmd.severity;
                    rec_next.last_time = cmd.now;
                    rec_next.count = 16'd1;
                    rec_next.recovered = 1'b0;
                end
                else if (cmd.upd_report)
                begin
                    rec_next.last_time = cmd.now;
                    if (rec_reg.count != 16'hFFFF)
                        rec_next.count = rec_reg.count + 16'd1;
                    rec_next.recovered = 1'b0;
                end
                else if (cmd.upd_flag)
                    rec_next.recovered = cmd.flag_value;
            end
        end
        rec_next.valid = valid_next;
    end

    // Hold the record
    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_comb
    begin
        rec = rec_reg;
        rec.valid = valid_reg;
    end
endmodule

// ===== dv/fault_record_table_test.sv =====
module fault_record_table_test;
    import frt_pkg::*;

    localparam int DEPTH = 16;
    localparam int NUM_RANDOM = 1150;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // func[1:0], category[4:2], severity[7:5], error_code[39:8], now_ms[71:40],
    // recovered_value[72], errors_active[73], in_recovery[74], zero pad
    logic [79:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // status[1:0], occurrence_count[17:2], health_score[24:18], evicted[25],
    // entries_used[30:26], zero pad
    logic [31:0] m_axis_tdata;
    logic        cfg_we;
    logic [31:0] cfg_wdata;

    // fields from the highest bit down, so status lands in the low bits
    typedef struct packed {
        logic [4:0]  used;
        logic        evicted;
        logic [6:0]  score;
        logic [15:0] count;
        logic [1:0]  status;
    } verdict_t;

    fault_record_table u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    // shadow copy of the table
    logic        tab_valid [DEPTH];
    logic [2:0]  tab_cat [DEPTH];
    logic [31:0] tab_code [DEPTH];
    logic [2:0]  tab_sev [DEPTH];
    logic [31:0] tab_time [DEPTH];
    logic [15:0] tab_count [DEPTH];
    logic        tab_rec [DEPTH];
    logic [31:0] window_ms;

    logic [79:0] request_queue[$];
    verdict_t    verdict_queue[$];
    int          fail_count;
    int          words_checked;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          n_report, n_evict, n_drop;

    always #10 clk = ~clk;

    function automatic logic [79:0] pack_request(
        func_t f, logic [2:0] cat, logic [2:0] sev, logic [31:0] code,
        logic [31:0] now, logic rv, logic ea, logic ir);
        return {5'd0, ir, ea, rv, now, code, sev, cat, f};
    endfunction

    function automatic int find_slot(logic [2:0] cat, logic [31:0] code);
        for (int i = 0; i < DEPTH; i++)
            if (tab_valid[i] && tab_cat[i] == cat && tab_code[i] == code)
                return i;
        return -1;
    endfunction

    // advance the shadow table by one request and return its result
    function automatic verdict_t apply_request(logic [79:0] w);
        func_t       f;
        logic [2:0]  cat;
        logic [2:0]  sev;
        logic [31:0] code;
        logic [31:0] now;
        verdict_t    v;
        int          k;
        int          sc;
        int          used;
        f = func_t'(w[1:0]);
        cat = w[4:2];
        sev = w[7:5];
        code = w[39:8];
        now = w[71:40];
        v = '0;
        k = find_slot(cat, code);
        case (f)
            FUNC_REPORT:
            begin
                if (k >= 0)
                begin
                    tab_time[k] = now;
                    if (tab_count[k] != 16'hFFFF) tab_count[k]++;
                    tab_rec[k] = 1'b0;
                    v.count = tab_count[k];
                    v.status = ST_DONE;
                end
                else
                begin
                    for (int i = 0; i < DEPTH && k < 0; i++)
                        if (!tab_valid[i]) k = i;
                    // full: evict the oldest recovered entry
                    if (k < 0)
                    begin
                        for (int i = 0; i < DEPTH; i++)
                            if (tab_valid[i] && tab_rec[i] &&
                                (k < 0 || tab_time[i] < tab_time[k]))
                                k = i;
                        if (k >= 0) v.evicted = 1'b1;
                    end
                    if (k < 0)
                        v.status = ST_DROPPED;
                    else
                    begin
                        tab_valid[k] = 1'b1;
                        tab_cat[k] = cat;
                        tab_code[k] = code;
                        tab_sev[k] = sev;
                        tab_time[k] = now;
                        tab_count[k] = 16'd1;
                        tab_rec[k] = 1'b0;
                        v.status = ST_INSERTED;
                        v.count = 16'd1;
                    end
                end
            end
            FUNC_SET_REC:
            begin
                if (k >= 0)
                begin
                    tab_rec[k] = w[72];
                    v.count = tab_count[k];
                end
                else
                    v.status = ST_NOT_FOUND;
            end
            FUNC_CLEAR:
                for (int i = 0; i < DEPTH; i++)
                    if (tab_valid[i] && tab_cat[i] == cat) tab_valid[i] = 1'b0;
            default:
            begin
                sc = 100;
                for (int i = 0; i < DEPTH; i++)
                    if (tab_valid[i] && !tab_rec[i] && (now - tab_time[i]) < window_ms)
                        case (tab_sev[i])
                            SEV_WARNING: sc = (sc > 5) ? sc - 5 : 0;
                            SEV_ERROR: sc = (sc > 10) ? sc - 10 : 0;
                            SEV_CRITICAL: sc = (sc > 20) ? sc - 20 : 0;
                            SEV_FATAL: sc = 0;
                            default: ;
                        endcase
                if (w[73]) sc = (sc > 10) ? sc - 10 : 0;
                if (w[74]) sc = (sc > 15) ? sc - 15 : 0;
                v.score = sc[6:0];
            end
        endcase
        used = 0;
        for (int i = 0; i < DEPTH; i++)
            if (tab_valid[i]) used++;
        v.used = used[4:0];
        return v;
    endfunction

    // driver: present the next queued request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (s_axis_tvalid && s_axis_tready)
                verdict_queue = {verdict_queue, apply_request(s_axis_tdata)};
            if (request_queue.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                s_axis_tdata <= request_queue.pop_front();
                s_axis_tvalid <= 1'b1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // monitor: compare each result word with the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        verdict_t want;
        verdict_t got;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[30:0];
                if (verdict_queue.size() == 0)
                begin
                    $error("result word with nothing expected");
                    fail_count++;
                end
                else
                begin
                    want = verdict_queue.pop_front();
                    words_checked++;
                    if (got.status != want.status)
                    begin
                        $error("status exp %0d got %0d", want.status, got.status);
                        fail_count++;
                    end
                    if (got.count != want.count)
                    begin
                        $error("occurrence_count exp %0d got %0d", want.count, got.count);
                        fail_count++;
                    end
                    if (got.score != want.score)
                    begin
                        $error("health_score exp %0d got %0d", want.score, got.score);
                        fail_count++;
                    end
                    if (got.evicted != want.evicted)
                    begin
                        $error("evicted exp %0d got %0d", want.evicted, got.evicted);
                        fail_count++;
                    end
                    if (got.used != want.used)
                    begin
                        $error("entries_used exp %0d got %0d", want.used, got.used);
                        fail_count++;
                    end
                    if (want.status == ST_INSERTED) n_report++;
                    if (want.evicted) n_evict++;
                    if (want.status == ST_DROPPED) n_drop++;
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // hold until every request is sent and answered
    task automatic drain();
        while (request_queue.size() > 0 || s_axis_tvalid || verdict_queue.size() > 0)
            @(posedge clk);
        repeat (2 * DEPTH + 6) @(posedge clk);
    endtask

    task automatic write_window(logic [31:0] val);
        cfg_wdata <= val;
        cfg_we <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        window_ms = val;
    endtask

    // random request biased toward a small key set so entries get hit again
    function automatic logic [79:0] random_request(logic [31:0] now);
        func_t       f;
        logic [2:0]  cat;
        logic [31:0] code;
        int          r;
        r = $urandom_range(99);
        f = (r < 50) ? FUNC_REPORT : (r < 75) ? FUNC_SET_REC : (r < 82) ? FUNC_CLEAR
            : FUNC_QUERY;
        if ($urandom_range(9) < 8)
        begin
            cat = 3'($urandom_range(5));
            code = 32'($urandom_range(7));
        end
        else
        begin
            cat = 3'($urandom_range(7));
            code = $urandom;
        end
        if (f == FUNC_QUERY && $urandom_range(3) == 0) now = $urandom;
        return pack_request(f, cat, 3'($urandom_range(7)), code, now,
                            $urandom_range(3) != 0, 1'($urandom_range(1)),
                            1'($urandom_range(1)));
    endfunction

    initial
    begin
        logic [31:0] now;
        clk = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        fail_count = 0;
        words_checked = 0;
        n_report = 0; n_evict = 0; n_drop = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        window_ms = WINDOW_RESET;
        for (int i = 0; i < DEPTH; i++) tab_valid[i] = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty queries at reset window, extremes, fill then overflow
        request_queue = {request_queue, pack_request(FUNC_QUERY, 3'd0, 3'd0, 32'd0, 32'd0,
                                                     1'b0, 1'b1, 1'b1)};
        request_queue = {request_queue, pack_request(FUNC_SET_REC, 3'd7, 3'd0,
                                                     32'hFFFFFFFF, 32'd0,
                                                     1'b1, 1'b0, 1'b0)};
        for (int i = 0; i < DEPTH; i++)
            request_queue = {request_queue,
                             pack_request(FUNC_REPORT, 3'(i % 6), 3'(i % 8),
                                          (i == 0) ? 32'hFFFFFFFF : 32'(i),
                                          32'(32'hFFFFFF00 + i), 1'b0, 1'b0, 1'b0)};
        request_queue = {request_queue, pack_request(FUNC_REPORT, 3'd7, 3'd4, 32'd99, 32'd5,
                                                     1'b0, 1'b0, 1'b0)};
        request_queue = {request_queue, pack_request(FUNC_QUERY, 3'd0, 3'd0, 32'd0,
                                                     32'hFFFFFFFF, 1'b0, 1'b0, 1'b1)};
        request_queue = {request_queue, pack_request(FUNC_SET_REC, 3'd1, 3'd0, 32'd1, 32'd0,
                                                     1'b1, 1'b0, 1'b0)};
        request_queue = {request_queue, pack_request(FUNC_SET_REC, 3'd3, 3'd0, 32'd3, 32'd0,
                                                     1'b1, 1'b0, 1'b0)};
        request_queue = {request_queue, pack_request(FUNC_REPORT, 3'd7, 3'd4, 32'd99, 32'd6,
                                                     1'b0, 1'b0, 1'b0)};
        request_queue = {request_queue, pack_request(FUNC_CLEAR, 3'd7, 3'd0, 32'd0, 32'd0,
                                                     1'b0, 1'b0, 1'b0)};
        request_queue = {request_queue, pack_request(FUNC_CLEAR, 3'd2, 3'd0, 32'd0, 32'd0,
                                                     1'b0, 1'b0, 1'b0)};
        drain();

        // random phases over idling profiles and window settings
        now = 32'd1000;
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: write_window(32'd0);
                1: write_window(32'hFFFFFFFF);
                2: write_window(32'd2000);
                3: write_window(32'd50);
                4: write_window(WINDOW_RESET);
                default: write_window($urandom);
            endcase
            send_idle_pct = (ph % 4 == 1) ? 45 : (ph % 4 == 3) ? 38 : 0;
            recv_stall_pct = (ph % 4 == 2) ? 45 : (ph % 4 == 3) ? 38 : 0;
            for (int n = 0; n < NUM_RANDOM / 6; n++)
            begin
                now += $urandom_range(300);
                if ($urandom_range(199) == 0) now = 32'hFFFFFFFF - $urandom_range(100);
                if ($urandom_range(99) == 0)
                    request_queue = {request_queue,
                                     pack_request(FUNC_REPORT, 3'd0, 3'd2,
                                                  32'd1, now, 1'b0, 1'b0, 1'b0)};
                else
                    request_queue = {request_queue, random_request(now)};
            end
            drain();
        end

        $display("checked %0d result words: %0d inserts, %0d evictions, %0d drops",
                 words_checked, n_report, n_evict, n_drop);
        $display("six window settings including 0 and all ones, four idling profiles");
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== fault_record_table.f =====
+incdir+rtl
rtl/frt_pkg.sv
rtl/frt_cell.sv
rtl/fault_record_table.sv
dv/fault_record_table_test.sv
